FILE: src/sms_pkg.sv
package sms_pkg;

   localparam int unsigned DIV_SEL_MAX = 6;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_CLOCK_MODE = 2'd0,
      REG_LSB_FIRST  = 2'd1,
      REG_DIVIDER    = 2'd2,
      REG_ENABLE     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic          miso;
      logic [7:0]    tx_byte;
      action_type    action;
   } item_type;

   typedef struct packed {
      logic          collision;
      logic          busy_res;
      logic          done_res;
      logic [7:0]    rx_byte;
      logic          mosi;
      logic          sck;
   } result_type;

   typedef struct packed {
      logic          we;
      reg_index_type index;
      logic [7:0]    data;
   } csr_write_type;

   function automatic logic out_bit(input logic [7:0] value, input logic lsb);
      out_bit = lsb ? value[0] : value[7];
   endfunction

endpackage

FILE: src/sms_engine.sv
module sms_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sms_pkg::item_type     item,
   input  sms_pkg::csr_write_type csr,
   output sms_pkg::result_type   result
);

   logic [1:0] mode_ff, mode_in;
   logic       lsb_ff, lsb_in;
   logic [2:0] div_ff, div_in;
   logic       enable_ff, enable_in;

   logic [7:0] shift_ff, shift_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [6:0] half_count_ff, half_count_in;
   logic       clock_level_ff, clock_level_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [7:0] received_ff, received_in;
   logic       mosi_ff, mosi_in;

   logic       polarity;
   logic       phase;
   logic [6:0] half;
   logic [6:0] half_sum;
   logic [3:0] bit_sum;
   logic [7:0] shifted;
   logic [7:0] shift_val;
   logic       coll;

   assign polarity = mode_ff[1];
   assign phase    = mode_ff[0];
   assign half     = 7'(1) << div_ff;
   assign half_sum = half_count_ff + 7'd1;
   assign bit_sum  = {1'b0, bit_count_ff} + 4'd1;
   assign shifted  = lsb_ff ? {item.miso, shift_ff[7:1]} : {shift_ff[6:0], item.miso};
   assign shift_val = phase ? shifted : shift_ff;

   always_comb begin
      mode_in        = mode_ff;
      lsb_in         = lsb_ff;
      div_in         = div_ff;
      enable_in      = enable_ff;
      shift_in       = shift_ff;
      bit_count_in   = bit_count_ff;
      half_count_in  = half_count_ff;
      clock_level_in = clock_level_ff;
      busy_in        = busy_ff;
      done_in        = done_ff;
      received_in    = received_ff;
      mosi_in        = mosi_ff;
      coll           = 1'b0;

      if (step) begin
         unique case (item.action)
            sms_pkg::ACT_TICK: begin
               if (busy_ff && enable_ff) begin
                  if (half_sum < half) begin
                     half_count_in = half_sum;
                  end else begin
                     half_count_in  = '0;
                     clock_level_in = ~clock_level_ff;
                     if (clock_level_ff == polarity) begin
                        if (phase) begin
                           mosi_in = sms_pkg::out_bit(shift_ff, lsb_ff);
                        end else begin
                           shift_in = shifted;
                        end
                     end else begin
                        shift_in = shift_val;
                        if (bit_sum[3]) begin
                           received_in    = shift_val;
                           done_in        = 1'b1;
                           busy_in        = 1'b0;
                           bit_count_in   = '0;
                           clock_level_in = polarity;
                        end else begin
                           bit_count_in = bit_sum[2:0];
                           if (!phase) begin
                              mosi_in = sms_pkg::out_bit(shift_val, lsb_ff);
                           end
                        end
                     end
                  end
               end
            end
            sms_pkg::ACT_WRITE: begin
               if (busy_ff) begin
                  coll = 1'b1;
               end else if (enable_ff) begin
                  shift_in       = item.tx_byte;
                  bit_count_in   = '0;
                  half_count_in  = '0;
                  clock_level_in = polarity;
                  busy_in        = 1'b1;
                  if (!phase) begin
                     mosi_in = sms_pkg::out_bit(item.tx_byte, lsb_ff);
                  end
               end
            end
            sms_pkg::ACT_READ: begin
               done_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (csr.we) begin
         unique case (csr.index)
            sms_pkg::REG_CLOCK_MODE: begin
               mode_in        = csr.data[1:0];
               busy_in        = 1'b0;
               bit_count_in   = '0;
               half_count_in  = '0;
               clock_level_in = csr.data[1];
            end
            sms_pkg::REG_LSB_FIRST: begin
               lsb_in = csr.data[0];
            end
            sms_pkg::REG_DIVIDER: begin
               div_in = (csr.data[2:0] > 3'(sms_pkg::DIV_SEL_MAX)) ?
                        3'(sms_pkg::DIV_SEL_MAX) : csr.data[2:0];
            end
            sms_pkg::REG_ENABLE: begin
               enable_in = csr.data[0];
               if (!csr.data[0]) begin
                  busy_in        = 1'b0;
                  bit_count_in   = '0;
                  half_count_in  = '0;
                  clock_level_in = polarity;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= '0;
         lsb_ff         <= 1'b0;
         div_ff         <= 3'd2;
         enable_ff      <= 1'b0;
         shift_ff       <= '0;
         bit_count_ff   <= '0;
         half_count_ff  <= '0;
         clock_level_ff <= 1'b0;
         busy_ff        <= 1'b0;
         done_ff        <= 1'b0;
         received_ff    <= '0;
         mosi_ff        <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         lsb_ff         <= lsb_in;
         div_ff         <= div_in;
         enable_ff      <= enable_in;
         shift_ff       <= shift_in;
         bit_count_ff   <= bit_count_in;
         half_count_ff  <= half_count_in;
         clock_level_ff <= clock_level_in;
         busy_ff        <= busy_in;
         done_ff        <= done_in;
         received_ff    <= received_in;
         mosi_ff        <= mosi_in;
      end
   end

   always_comb begin
      result.sck       = clock_level_in;
      result.mosi      = mosi_in;
      result.rx_byte   = received_in;
      result.done_res  = done_in;
      result.busy_res  = busy_in;
      result.collision = coll;
   end

endmodule

FILE: src/spi_master_byte_shifter.sv
// rsp_tvalid rises once an accepted item has passed from the input register
// into the result register; a stalled output holds it in the input register.
// Throughput: 1 item per cycle while rsp_tready is high; the input register and
// engine state update in one pass; the result register lets a stalled output overlap.
// Reset: synchronous, active high; clears the engine state (divider_select to 2,
// others to 0) and empties both pipeline stages. csr writes are taken every cycle.
module spi_master_byte_shifter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tx_byte[7:0], miso[8], zero pad
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sck[0], mosi[1], rx_byte[9:2], done_res[10],
                                    // busy_res[11], collision[12], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic                   in_valid_ff, in_valid_in;
   sms_pkg::item_type      item_ff, item_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sms_pkg::result_type    result_ff, result_in;
   sms_pkg::result_type    engine_result;
   sms_pkg::csr_write_type csr;
   logic                   advance;
   logic                   req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      csr.we    = csr_valid;
      csr.index = sms_pkg::reg_index_type'(csr_index);
      csr.data  = csr_data;
   end

   sms_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .csr    (csr),
      .result (engine_result)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      item_in      = item_ff;
      result_in    = result_ff;
      if (req_take) begin
         item_in.action  = sms_pkg::action_type'(req_tuser);
         item_in.tx_byte = req_tdata[7:0];
         item_in.miso    = req_tdata[8];
      end
      if (advance) begin
         result_in = engine_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff};

endmodule
